// ===== hw/rtl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, widths and helpers for the open-addressed hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  // Table geometry.
  localparam int unsigned SLOTS  = 64;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned SIZE_W = IDX_W + 1;
  localparam int unsigned KEY_W  = 31;

  // Remainder unit takes two key bits per cycle.
  localparam int unsigned DIV_STEPS = (KEY_W + 1) / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_e;

  // Clamp the configured size to the range 1..SLOTS.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    if (s > SIZE_W'(SLOTS)) r = SIZE_W'(SLOTS);
    return r;
  endfunction

endpackage

// ===== hw/rtl/oaht_mod.sv =====
// ----------------------------------------------------------------------------
// oaht_mod
// Iterative remainder unit: key modulo table size, two bits per cycle.
// ----------------------------------------------------------------------------
module oaht_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [oaht_pkg::KEY_W-1:0]   key_i,
  input  logic [oaht_pkg::SIZE_W-1:0]  size_i,
  output logic                         done_o,
  output logic [oaht_pkg::IDX_W-1:0]   rem_o
);

  localparam int unsigned DVD_W = 2 * oaht_pkg::DIV_STEPS;

  // One restoring step: shift in a bit, subtract the modulus if it fits.
  function automatic logic [oaht_pkg::IDX_W-1:0] rem_step(
    input logic [oaht_pkg::IDX_W-1:0]  r,
    input logic                        b,
    input logic [oaht_pkg::SIZE_W-1:0] n
  );
    logic [oaht_pkg::SIZE_W-1:0] t;
    t = {r, b};
    if (t >= n) t = t - n;
    return t[oaht_pkg::IDX_W-1:0];
  endfunction

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [oaht_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [DVD_W-1:0]                  dvd_q, dvd_d;
  logic [oaht_pkg::IDX_W-1:0]        rem_q, rem_d;
  logic [oaht_pkg::IDX_W-1:0]        rem_mid;

  // Two dependent steps per cycle on narrow values.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    rem_mid = rem_step(rem_q, dvd_q[DVD_W-1], size_i);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = DVD_W'(key_i);
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = rem_step(rem_mid, dvd_q[DVD_W-2], size_i);
      dvd_d = {dvd_q[DVD_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == oaht_pkg::DIV_CNT_W'(oaht_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/open_addressing_hash_table.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressed set of keys with triangular probing.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request kind
//   (search, insert, delete) and tdata the key. Each request yields one
//   result on the m_axis channel: tuser is the success flag and tdata the
//   slot. The table size must be written on the cfg channel only while the
//   block is idle; the block itself does not enforce this. The cfg channel
//   is always ready. One request is in work at a time. The home slot is
//   found by a remainder unit, then the probe walk reads one slot per cycle
//   from the key memory, which has a registered read port.
//   The result sits in an output register, so the next request is taken
//   while a result waits; when the receiver stalls, the block holds the
//   next finished result until the output register frees up.
//   Reset empties every slot (the used bits clear at once, no sweep) and
//   sets the table size to 64.
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: table size.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [oaht_pkg::SIZE_W-1:0]   cfg_data_i,
  // Request channel.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [30:0] key
  input  logic [1:0]                    s_axis_tuser,  // [1:0] req_type
  // Result channel.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [5:0] slot
  output logic [0:0]                    m_axis_tuser   // [0] ok
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int unsigned IW = oaht_pkg::IDX_W;
  localparam int unsigned SW = oaht_pkg::SIZE_W;
  localparam int unsigned KW = oaht_pkg::KEY_W;

  logic [1:0]                 state_q, state_d;
  logic [SW-1:0]              cfg_size_q;
  logic [SW-1:0]              size_n;
  oaht_pkg::req_e             req_q;
  logic [KW-1:0]              key_q;
  logic                       in_acc;

  logic                       mod_done;
  logic [IW-1:0]              mod_rem;

  logic                       iss_en_q, iss_en_d;
  logic [IW-1:0]              iss_h_q, iss_h_d;
  logic [SW-1:0]              iss_k_q, iss_k_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [IW-1:0]              chk_h_q;
  logic [SW-1:0]              chk_k_q;
  logic                       issue;
  logic [SW:0]                h_sum;
  logic [IW-1:0]              h_next;

  logic [KW-1:0]              key_mem [oaht_pkg::SLOTS];
  logic [KW-1:0]              rd_q;
  logic [oaht_pkg::SLOTS-1:0] used_q;

  logic                       probe_emp, probe_hit, probe_last, walk_end;
  logic                       res_ok;
  logic                       mem_wr, used_set, used_clr;
  logic                       ok_q;
  logic [IW-1:0]              slot_q;
  logic                       out_vld_q;
  logic                       out_ok_q;
  logic [IW-1:0]              out_slot_q;
  logic                       out_load;

  assign size_n        = oaht_pkg::eff_size(cfg_size_q);
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= SW'(oaht_pkg::SLOTS);
    end else if (cfg_valid_i) begin
      cfg_size_q <= cfg_data_i;
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= oaht_pkg::req_e'(s_axis_tuser);
      key_q <= s_axis_tdata[KW-1:0];
    end
  end

  // Home slot.
  oaht_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .key_i   (s_axis_tdata[KW-1:0]),
    .size_i  (size_n),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // Next probe position: one compare and subtract keeps it below the size.
  always_comb begin
    h_sum = (SW+1)'(iss_h_q) + (SW+1)'(iss_k_q) + 1'b1;
    if (h_sum >= (SW+1)'(size_n)) h_sum = h_sum - (SW+1)'(size_n);
    h_next = h_sum[IW-1:0];
  end

  // Probe check: the read issued last cycle is compared now.
  assign probe_last = (chk_k_q == size_n);
  assign probe_emp  = !used_q[chk_h_q];
  assign probe_hit  = !probe_emp && (rd_q == key_q) && !probe_last;
  assign walk_end   = (state_q == ST_WALK) && chk_vld_q &&
                      (probe_emp || probe_hit || probe_last);
  assign issue      = (state_q == ST_WALK) && iss_en_q && !walk_end;

  // Outcome of the walk for each request kind.
  always_comb begin
    res_ok   = 1'b0;
    mem_wr   = 1'b0;
    used_set = 1'b0;
    used_clr = 1'b0;
    case (req_q)
      oaht_pkg::REQ_SEARCH: res_ok = probe_hit;
      oaht_pkg::REQ_INSERT: begin
        res_ok   = probe_hit || probe_emp;
        mem_wr   = walk_end && probe_emp;
        used_set = walk_end && probe_emp;
      end
      oaht_pkg::REQ_DELETE: begin
        res_ok   = probe_hit;
        used_clr = walk_end && probe_hit;
      end
      default: res_ok = 1'b0;
    endcase
  end

  // Sequencer and probe pipeline.
  always_comb begin
    state_d   = state_q;
    iss_en_d  = iss_en_q;
    iss_h_d   = iss_h_q;
    iss_k_d   = iss_k_q;
    chk_vld_d = issue;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MOD;
      ST_MOD: begin
        if (mod_done) begin
          state_d  = ST_WALK;
          iss_en_d = 1'b1;
          iss_h_d  = mod_rem;
          iss_k_d  = '0;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_d   = ST_DONE;
          iss_en_d  = 1'b0;
          chk_vld_d = 1'b0;
        end else if (issue) begin
          iss_h_d  = h_next;
          iss_k_d  = iss_k_q + 1'b1;
          iss_en_d = (iss_k_q != size_n);
        end
      end
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iss_en_q  <= 1'b0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_en_q  <= iss_en_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_h_q <= iss_h_d;
    iss_k_q <= iss_k_d;
    if (issue) begin
      chk_h_q <= iss_h_q;
      chk_k_q <= iss_k_q;
    end
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_wr) key_mem[chk_h_q] <= key_q;
    rd_q <= key_mem[iss_h_q];
  end

  // Used bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (used_set) begin
      used_q[chk_h_q] <= 1'b1;
    end else if (used_clr) begin
      used_q[chk_h_q] <= 1'b0;
    end
  end

  // Finished result, held until the output register is free.
  always_ff @(posedge clk_i) begin
    if (walk_end) begin
      ok_q   <= res_ok;
      slot_q <= res_ok ? chk_h_q : '0;
    end
  end

  // Output register.
  assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ok_q   <= ok_q;
      out_slot_q <= slot_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = 8'(out_slot_q);
  assign m_axis_tuser  = out_ok_q;

endmodule

// ===== hw/rtl/oaht_checker.sv =====
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks for the hash table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module oaht_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [oaht_pkg::SIZE_W-1:0]  cfg_data_i,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [31:0]                  s_axis_tdata,
  input logic [1:0]                   s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [7:0]                   m_axis_tdata,
  input logic [0:0]                   m_axis_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One request in work at a time: no accept right after an accept.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // A failed request reports slot zero.
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
    else $error("failed result carries a slot");

  // The slot never exceeds the table range.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00)
    else $error("slot outside the table");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);
